### rtl/stt_pkg.sv
package stt_pkg;

  localparam int TEXT_MAX_DEF = 256;
  localparam logic [62:0] VAL_MAX = {63{1'b1}};
  // largest accumulator that still takes a digit without saturating check
  localparam logic [62:0] VAL_DIV10 = 63'd922337203685477580;

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_IDENT  = 3'd1,
    M_NUMBER = 3'd2,
    M_STRING = 3'd3,
    M_HALTED = 3'd4,
    M_ENDED  = 3'd5
  } mode_t;

  localparam logic [3:0] T_EOF    = 4'd0;
  localparam logic [3:0] T_IDENT  = 4'd1;
  localparam logic [3:0] T_FUNC   = 4'd2;
  localparam logic [3:0] T_INT    = 4'd3;
  localparam logic [3:0] T_FLOAT  = 4'd4;
  localparam logic [3:0] T_STRING = 4'd5;
  localparam logic [3:0] T_ADD    = 4'd6;
  localparam logic [3:0] T_SUB    = 4'd7;
  localparam logic [3:0] T_MUL    = 4'd8;
  localparam logic [3:0] T_DIV    = 4'd9;
  localparam logic [3:0] T_MOD    = 4'd10;
  localparam logic [3:0] T_POW    = 4'd11;
  localparam logic [3:0] T_ASSIGN = 4'd12;
  localparam logic [3:0] T_ERROR  = 4'd13;

  localparam logic [2:0] KW_NONE = 3'd7;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [3:0]  token_type;
    logic [62:0] number_value;
    logic [8:0]  fraction_digits;
    logic [7:0]  text_length;
    logic [7:0]  text_byte;
    logic [31:0] token_line;
    logic [31:0] token_column;
    logic        last;
  } res_t;

  // up to two results of one input
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } pair_t;

  localparam int RES_W  = $bits(res_t);
  localparam int PAIR_W = $bits(pair_t);

endpackage

### rtl/stt_front.sv
module stt_front #(
  parameter int TEXT_MAX = stt_pkg::TEXT_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_op,
  input  logic [7:0]    in_ch,
  input  logic          q_full,
  output logic          q_push,
  output stt_pkg::pair_t q_data
);
  import stt_pkg::*;

  localparam logic [7:0] STORE_LIM = 8'(TEXT_MAX - 1);

  mode_t       mode_r, mode_nxt;
  logic [31:0] line_r, line_nxt, col_r, col_nxt;
  logic [31:0] sline_r, sline_nxt, scol_r, scol_nxt;
  logic        pend_r, pend_nxt;
  logic [62:0] acc_r, acc_nxt;
  logic        pt_r, pt_nxt;
  logic [8:0]  frac_r, frac_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [2:0]  kw_r, kw_nxt;

  pair_t       pr;
  logic        take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  function automatic res_t mk(logic k, logic [3:0] t, logic [62:0] v, logic [8:0] f,
                              logic [7:0] l, logic [7:0] b, logic [31:0] sl,
                              logic [31:0] sc);
    res_t r;
    r.kind = k; r.token_type = t; r.number_value = v; r.fraction_digits = f;
    r.text_length = l; r.text_byte = b; r.token_line = sl; r.token_column = sc;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return l >= "a" && l <= "z";
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] kw_ch(logic [7:0] p);
    logic [7:0] r;
    case (p[1:0])
      2'd0: r = "f";
      2'd1: r = "u";
      2'd2: r = "n";
      default: r = "c";
    endcase
    return r;
  endfunction

  // classify one transaction; mirrors the per-byte lexer step
  always_comb begin
    logic       fall, emitted;
    logic [3:0] ot;
    logic [62:0] d;
    mode_nxt = mode_r; line_nxt = line_r; col_nxt = col_r;
    sline_nxt = sline_r; scol_nxt = scol_r; pend_nxt = pend_r;
    acc_nxt = acc_r; pt_nxt = pt_r; frac_nxt = frac_r; len_nxt = len_r; kw_nxt = kw_r;
    pr = '0;
    fall = 1'b0; emitted = 1'b0; ot = T_ERROR;
    d = {55'd0, in_ch - 8'd48};
    if (mode_r == M_HALTED) begin
      pr.cnt = 2'd0;
    end else if (in_op) begin
      if (mode_r == M_ENDED) begin
        pr.r0 = mk(1'b1, T_EOF, '0, '0, '0, '0, sline_r, scol_r);
        pr.cnt = 2'd1;
      end else begin
        col_nxt = col_r + 32'd1;
        if (mode_r == M_IDENT) begin
          pr.r0 = mk(1'b1, (kw_r == 3'd4) ? T_FUNC : T_IDENT, '0, '0, len_r, '0,
                     sline_r, scol_r);
          emitted = 1'b1;
        end else if (mode_r == M_NUMBER) begin
          pr.r0 = mk(1'b1, pt_r ? T_FLOAT : T_INT, acc_r, pt_r ? frac_r : 9'd0, len_r,
                     '0, sline_r, scol_r);
          emitted = 1'b1;
        end else if (mode_r == M_STRING) begin
          col_nxt = col_r + 32'd2;
          pr.r0 = mk(1'b1, T_STRING, '0, '0, len_r, '0, sline_r, scol_r);
          emitted = 1'b1;
        end
        if (emitted || pend_r) begin
          sline_nxt = line_r; scol_nxt = col_nxt; pend_nxt = 1'b0;
        end
        if (emitted) begin
          pr.r1 = mk(1'b1, T_EOF, '0, '0, '0, '0, line_r, col_nxt);
          pr.cnt = 2'd2;
        end else begin
          pr.r0 = mk(1'b1, T_EOF, '0, '0, '0, '0, sline_nxt, scol_nxt);
          pr.cnt = 2'd1;
        end
        mode_nxt = M_ENDED;
      end
    end else if (mode_r != M_ENDED) begin
      if (in_ch == 8'h0A) begin
        line_nxt = line_r + 32'd1; col_nxt = '0;
      end else begin
        col_nxt = col_r + 32'd1;
      end
      unique case (mode_r)
        M_IDENT: begin
          if (is_alpha(in_ch) || is_dig(in_ch) || in_ch == "_") begin
            if (len_r < STORE_LIM) begin
              len_nxt = len_r + 8'd1;
              pr.r0 = mk(1'b0, '0, '0, '0, len_nxt, in_ch, sline_r, scol_r);
              pr.cnt = 2'd1;
              kw_nxt = (kw_r == 3'(len_r) && len_r < 8'd4 && in_ch == kw_ch(len_r))
                       ? kw_r + 3'd1 : KW_NONE;
            end
          end else begin
            pr.r0 = mk(1'b1, (kw_r == 3'd4) ? T_FUNC : T_IDENT, '0, '0, len_r, '0,
                       sline_r, scol_r);
            pr.cnt = 2'd1; emitted = 1'b1; fall = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_dig(in_ch)) begin
            if (len_r < STORE_LIM) begin
              len_nxt = len_r + 8'd1;
              pr.r0 = mk(1'b0, '0, '0, '0, len_nxt, in_ch, sline_r, scol_r);
              pr.cnt = 2'd1;
              if (acc_r > VAL_DIV10 || (acc_r == VAL_DIV10 && d > 63'd7))
                acc_nxt = VAL_MAX;
              else
                acc_nxt = (acc_r << 3) + (acc_r << 1) + d;
              if (pt_r) frac_nxt = frac_r + 9'd1;
            end
          end else if (in_ch == "." && !pt_r) begin
            pt_nxt = 1'b1;
            if (len_r < STORE_LIM) begin
              len_nxt = len_r + 8'd1;
              pr.r0 = mk(1'b0, '0, '0, '0, len_nxt, in_ch, sline_r, scol_r);
              pr.cnt = 2'd1;
            end
          end else begin
            pr.r0 = mk(1'b1, pt_r ? T_FLOAT : T_INT, acc_r, pt_r ? frac_r : 9'd0, len_r,
                       '0, sline_r, scol_r);
            pr.cnt = 2'd1; emitted = 1'b1; fall = 1'b1;
          end
        end
        M_STRING: begin
          if (in_ch == "\"") begin
            pr.r0 = mk(1'b1, T_STRING, '0, '0, len_r, '0, sline_r, scol_r);
            pr.cnt = 2'd1; mode_nxt = M_IDLE; pend_nxt = 1'b1;
          end else if (len_r < STORE_LIM) begin
            len_nxt = len_r + 8'd1;
            pr.r0 = mk(1'b0, '0, '0, '0, len_nxt, in_ch, sline_r, scol_r);
            pr.cnt = 2'd1;
          end
        end
        default: fall = 1'b1;
      endcase
      if (fall) begin
        logic [31:0] sl, sc;
        logic        store_one, give;
        res_t        rr;
        sl = sline_r; sc = scol_r;
        if (emitted || pend_r) begin
          sl = line_nxt; sc = col_nxt; pend_nxt = 1'b0;
        end
        sline_nxt = sl; scol_nxt = sc;
        if (emitted) mode_nxt = M_IDLE;
        store_one = 1'b0; give = 1'b0; rr = '0;
        if (in_ch == 8'h20 || in_ch == 8'h09 || in_ch == 8'h0A || in_ch == 8'h0D) begin
          give = 1'b0;
        end else if (is_alpha(in_ch) || in_ch == "_") begin
          mode_nxt = M_IDENT; acc_nxt = '0; pt_nxt = 1'b0; frac_nxt = '0;
          len_nxt = 8'd1; kw_nxt = (in_ch == "f") ? 3'd1 : KW_NONE;
          store_one = 1'b1;
        end else if (is_dig(in_ch)) begin
          mode_nxt = M_NUMBER; acc_nxt = d; pt_nxt = 1'b0; frac_nxt = '0;
          len_nxt = 8'd1; kw_nxt = '0; store_one = 1'b1;
        end else if (in_ch == "\"") begin
          mode_nxt = M_STRING; acc_nxt = '0; pt_nxt = 1'b0; frac_nxt = '0;
          len_nxt = '0; kw_nxt = '0;
        end else begin
          unique case (in_ch)
            "+": ot = T_ADD;
            "-": ot = T_SUB;
            "*": ot = T_MUL;
            "/": ot = T_DIV;
            "%": ot = T_MOD;
            "^": ot = T_POW;
            "=": ot = T_ASSIGN;
            default: ot = T_ERROR;
          endcase
          give = 1'b1;
          if (ot == T_ERROR) mode_nxt = M_HALTED;
          else pend_nxt = 1'b1;
        end
        if (store_one)
          rr = mk(1'b0, '0, '0, '0, 8'd1, in_ch, sl, sc);
        else if (give)
          rr = mk(1'b1, ot, '0, '0, '0, '0, sl, sc);
        if (store_one || give) begin
          if (emitted) begin
            pr.r1 = rr; pr.cnt = 2'd2;
          end else begin
            pr.r0 = rr; pr.cnt = 2'd1;
          end
        end
      end
    end
    if (pr.cnt == 2'd1) pr.r0.last = 1'b1;
    if (pr.cnt == 2'd2) pr.r1.last = 1'b1;
  end

  assign q_push = take && (pr.cnt != 2'd0);
  assign q_data = pr;

  // advance lexer state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; line_r <= 32'd1; col_r <= '0; sline_r <= 32'd1;
      scol_r <= 32'd1; pend_r <= 1'b1; acc_r <= '0; pt_r <= 1'b0;
      frac_r <= '0; len_r <= '0; kw_r <= '0;
    end else if (take) begin
      mode_r <= mode_nxt; line_r <= line_nxt; col_r <= col_nxt;
      sline_r <= sline_nxt; scol_r <= scol_nxt; pend_r <= pend_nxt;
      acc_r <= acc_nxt; pt_r <= pt_nxt; frac_r <= frac_nxt;
      len_r <= len_nxt; kw_r <= kw_nxt;
    end
  end

endmodule

### rtl/stt_queue.sv
module stt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  stt_pkg::pair_t wdata,
  output logic           full,
  output logic           rvalid,
  input  logic           pop,
  output stt_pkg::pair_t rdata
);
  import stt_pkg::*;

  // two-entry queue of result pairs
  pair_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full   = cnt_r == 2'd2;
  assign rvalid = cnt_r != 2'd0;
  assign rdata  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/stt_back.sv
module stt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  stt_pkg::pair_t q_data,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output stt_pkg::res_t  out_res
);
  import stt_pkg::*;

  // index of the result within the head pair
  logic sel_r;
  logic fire;

  assign out_tvalid = q_valid;
  assign out_res    = sel_r ? q_data.r1 : q_data.r0;
  assign fire       = out_tvalid && out_tready;
  assign q_pop      = fire && (sel_r || q_data.cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) sel_r <= 1'b0;
    else if (fire) sel_r <= !q_pop;
  end

endmodule

### rtl/source_text_tokenizer.sv
// Each input's results are registered in the pair queue before they are offered.
// Throughput: one input per cycle when each gives at most one result and the output
// is not stalled; an input with two results sends them in turn over the single out port.
// A two-entry pair queue lets the front and the output stall on their own.
// Reset (rst_n low, synchronous) clears the lexer state and the queue.
module source_text_tokenizer #(
  parameter int TEXT_MAX = stt_pkg::TEXT_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [15:0]   in_tdata,  // ch[7:0], zero pad
  input  logic          in_tuser,  // op
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [159:0]  out_tdata, // number_value, fraction_digits, text_length,
                                   // text_byte, token_line, token_column, pad
  output logic [4:0]    out_tuser, // kind, token_type[3:0]
  output logic          out_tlast
);
  import stt_pkg::*;

  logic  q_full, q_push, q_valid, q_pop;
  pair_t q_w, q_r;
  res_t  res;

  stt_front #(.TEXT_MAX(TEXT_MAX)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_op(in_tuser),
    .in_ch(in_tdata[7:0]), .q_full, .q_push, .q_data(q_w)
  );

  stt_queue u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_w), .full(q_full),
    .rvalid(q_valid), .pop(q_pop), .rdata(q_r)
  );

  stt_back u_back (
    .clk, .rst_n, .q_valid, .q_data(q_r), .q_pop, .out_tvalid, .out_tready,
    .out_res(res)
  );

  assign out_tdata = {8'd0, res.token_column, res.token_line, res.text_byte,
                      res.text_length, res.fraction_digits, res.number_value};
  assign out_tuser = {res.token_type, res.kind};
  assign out_tlast = res.last;

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_tready) else $error("accepted into full queue");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> out_tvalid && out_tready && out_tlast) else $error("pop before last");
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[4:1] == T_EOF)
    else $error("echo with token type");

endmodule
